// ===== rtl/pidid_pkg.sv =====
// Shared constants and codes for the PID step unit with integral deadband.
// Holds the data widths, the fixed-point format and the register index codes.
// Depends on nothing.
`default_nettype none

package pidid_pkg;

  // Width of every data word and of the fraction in Q16.16
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;

  // Width of the configuration index and of the magnitude registers
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MAG_W     = 31;

  // Reset value of the integral clamp
  localparam logic [MAG_W-1:0] LIMIT_RESET = 31'h7fff_ffff;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_LIMIT    = 3'd3,
    CFG_DEADBAND = 3'd4
  } cfg_idx_e;

  // Command codes of an input word
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

endpackage : pidid_pkg

`default_nettype wire

// ===== rtl/pid_controller_integral_deadband_unit.sv =====
// Channel  | Direction | Handshake                 | Payload
// in       | sink      | in_valid_i / in_ready_o   | cmd, set_point, measured, time_step
// out      | source    | out_valid_o / out_ready_i | drive, current_error, flags
// cfg      | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A compute word is worked through in single steps by a sequencer: the
// derivative comes from a bit-serial divider, one quotient bit per cycle, the
// rest are single steps around one shared 33x33 multiplier. With a zero time
// step or a derivative known to clip, the divider and its finishing step are
// skipped. A clear word goes through a single clear step. Input is taken only
// while the sequencer is idle, so a new word is taken only once the last one
// is through; a finished result waits in the output register, and the
// sequencer holds at its last step while that register is still full.
// Reset is asynchronous, active low; it clears gains, deadband, integral and
// previous error and sets the integral clamp to its maximum.
//
// PID controller step with integral deadband and clamp, Q16.16 fixed point.
// Depends on pidid_pkg.
`default_nettype none

module pid_controller_integral_deadband_unit
  import pidid_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Input words
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic                     cmd_i,
  input  wire logic signed [DATA_W-1:0] set_point_i,
  input  wire logic signed [DATA_W-1:0] measured_i,
  input  wire logic        [DATA_W-1:0] time_step_i,
  // Result words
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic signed [DATA_W-1:0] drive_o,
  output      logic signed [DATA_W-1:0] current_error_o,
  output      logic                     drive_saturated_o,
  output      logic                     zero_step_o,
  // Configuration writes
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_IMUL,
    S_IACC,
    S_DSET,
    S_DIV,
    S_DFIN,
    S_PMUL,
    S_IMUL2,
    S_DMUL,
    S_SUM,
    S_SAT,
    S_CLR
  } state_e;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned TERM_W = PROD_W - FRAC_BITS;
  localparam int unsigned ACC_W  = TERM_W + 2;
  localparam int unsigned ISUM_W = TERM_W + 1;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-64'sd2147483648);
  localparam logic signed [DATA_W-1:0] DW_HI = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] DW_LO = 32'sh8000_0000;

  // Control and architectural state
  state_e                     state_q;
  logic                       out_valid_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [DATA_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic [MAG_W-1:0]           limit_q, deadband_q;
  logic signed [DATA_W-1:0]   integral_q, integral_d;
  logic signed [DATA_W-1:0]   prev_q;
  logic signed [DATA_W-1:0]   drive_q, error_out_q;
  logic                       sat_out_q, zero_out_q;

  // Datapath working registers
  logic signed [DATA_W-1:0]   sp_q, meas_q, e_q, d_q;
  logic        [DATA_W-1:0]   dt_q, rem_q, qsh_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       neg_q, clip_q, zero_q;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o        = (state_q == S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign drive_o           = drive_q;
  assign current_error_o   = error_out_q;
  assign drive_saturated_o = sat_out_q;
  assign zero_step_o       = zero_out_q;

  // Error: set point minus measurement, saturated
  logic signed [DATA_W:0]   err_wide;
  logic                     err_ovf;
  logic signed [DATA_W-1:0] err_sat;
  assign err_wide = {sp_q[DATA_W-1], sp_q} - {meas_q[DATA_W-1], meas_q};
  assign err_ovf  = err_wide[DATA_W] != err_wide[DATA_W-1];
  assign err_sat  = err_ovf ? (err_wide[DATA_W] ? DW_LO : DW_HI) : err_wide[DATA_W-1:0];

  // Shared multiplier, operands chosen by the sequencer
  logic signed [DATA_W:0]   mul_a, mul_b;
  logic signed [2*DATA_W+1:0] mul_p;
  always_comb begin
    unique case (state_q)
      S_IMUL: begin
        mul_a = {e_q[DATA_W-1], e_q};
        mul_b = {1'b0, dt_q};
      end
      S_PMUL: begin
        mul_a = {gain_p_q[DATA_W-1], gain_p_q};
        mul_b = {e_q[DATA_W-1], e_q};
      end
      S_IMUL2: begin
        mul_a = {gain_i_q[DATA_W-1], gain_i_q};
        mul_b = {integral_q[DATA_W-1], integral_q};
      end
      S_DMUL: begin
        mul_a = {gain_d_q[DATA_W-1], gain_d_q};
        mul_b = {d_q[DATA_W-1], d_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Floor of the registered product over the fraction
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [TERM_W-1:0] term;
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign term    = prod_sh[TERM_W-1:0];

  // Integral update with deadband and clamp
  logic [DATA_W-1:0]        e_mag;
  logic signed [ISUM_W-1:0] isum, ilim;
  assign e_mag = e_q[DATA_W-1] ? DATA_W'(-e_q) : DATA_W'(e_q);
  assign isum  = ISUM_W'(integral_q) + ISUM_W'(term);
  assign ilim  = ISUM_W'({1'b0, limit_q});
  always_comb begin
    integral_d = integral_q;
    if (e_mag > {1'b0, deadband_q}) begin
      priority if (isum > ilim) begin
        integral_d = DATA_W'(ilim);
      end else if (isum < -ilim) begin
        integral_d = DATA_W'(-ilim);
      end else begin
        integral_d = isum[DATA_W-1:0];
      end
    end
  end

  // Derivative setup: change of error, its magnitude and the overflow test
  logic signed [DATA_W:0]   diff;
  logic [DATA_W-1:0]        diff_mag;
  logic                     div_ovf;
  assign diff     = {e_q[DATA_W-1], e_q} - {prev_q[DATA_W-1], prev_q};
  assign diff_mag = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
  assign div_ovf  = {{(DATA_W-FRAC_BITS){1'b0}}, diff_mag[DATA_W-1:DATA_W-FRAC_BITS]} >= dt_q;

  // One restoring divider step
  logic [DATA_W:0] trial;
  logic            qbit;
  assign trial = {rem_q, qsh_q[DATA_W-1]} - {1'b0, dt_q};
  assign qbit  = !trial[DATA_W];

  // Sign and saturate the quotient
  logic signed [DATA_W-1:0] quot_s;
  logic                     quot_clip;
  always_comb begin
    if (neg_q) begin
      quot_clip = qsh_q > 32'h8000_0000;
      quot_s    = quot_clip ? DW_LO : DATA_W'(-qsh_q);
    end else begin
      quot_clip = qsh_q[DATA_W-1];
      quot_s    = quot_clip ? DW_HI : qsh_q;
    end
  end

  // Drive sum and saturation
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [DATA_W-1:0] drive_sat;
  logic                     drive_clip;
  assign acc_next   = acc_q + ACC_W'(term);
  assign drive_clip = (acc_q > ACC_HI) || (acc_q < ACC_LO);
  assign drive_sat  = (acc_q > ACC_HI) ? DW_HI :
                      (acc_q < ACC_LO) ? DW_LO : acc_q[DATA_W-1:0];

  // Sequencer, state and result register
  state_e state_d;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = (cmd_i == CMD_CLEAR) ? S_CLR : S_ERR;
      S_ERR:   state_d = S_IMUL;
      S_IMUL:  state_d = S_IACC;
      S_IACC:  state_d = S_DSET;
      S_DSET:  state_d = (dt_q == '0 || div_ovf) ? S_PMUL : S_DIV;
      S_DIV:   if (cnt_q == '0) state_d = S_DFIN;
      S_DFIN:  state_d = S_PMUL;
      S_PMUL:  state_d = S_IMUL2;
      S_IMUL2: state_d = S_DMUL;
      S_DMUL:  state_d = S_SUM;
      S_SUM:   state_d = S_SAT;
      S_SAT:   if (out_free) state_d = S_IDLE;
      S_CLR:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      limit_q     <= LIMIT_RESET;
      deadband_q  <= '0;
      integral_q  <= '0;
      prev_q      <= '0;
      drive_q     <= '0;
      error_out_q <= '0;
      sat_out_q   <= 1'b0;
      zero_out_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Raise the result on a final step, drop it once taken
      if ((state_q == S_SAT || state_q == S_CLR) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Register writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GAIN_P:   gain_p_q   <= cfg_data_i;
          CFG_GAIN_I:   gain_i_q   <= cfg_data_i;
          CFG_GAIN_D:   gain_d_q   <= cfg_data_i;
          CFG_LIMIT:    limit_q    <= cfg_data_i[MAG_W-1:0];
          CFG_DEADBAND: deadband_q <= cfg_data_i[MAG_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && cmd_i == CMD_CLEAR) begin
            integral_q <= '0;
            prev_q     <= '0;
          end
        end
        S_IACC: integral_q <= integral_d;
        S_DSET: begin
          prev_q <= e_q;
          cnt_q  <= CNT_W'(DATA_W - 1);
        end
        S_DIV:  cnt_q <= cnt_q - 1'b1;
        S_SAT: begin
          if (out_free) begin
            drive_q     <= drive_sat;
            error_out_q <= e_q;
            sat_out_q   <= clip_q || drive_clip;
            zero_out_q  <= zero_q;
          end
        end
        S_CLR: begin
          if (out_free) begin
            drive_q     <= '0;
            error_out_q <= '0;
            sat_out_q   <= 1'b0;
            zero_out_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[PROD_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        sp_q   <= set_point_i;
        meas_q <= measured_i;
        dt_q   <= time_step_i;
      end
      S_ERR: begin
        e_q    <= err_sat;
        clip_q <= err_ovf;
        zero_q <= 1'b0;
      end
      S_DSET: begin
        neg_q <= diff[DATA_W];
        rem_q <= {{(DATA_W-FRAC_BITS){1'b0}}, diff_mag[DATA_W-1:DATA_W-FRAC_BITS]};
        qsh_q <= {diff_mag[DATA_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        priority if (dt_q == '0) begin
          zero_q <= 1'b1;
          d_q    <= '0;
        end else if (div_ovf) begin
          clip_q <= 1'b1;
          d_q    <= diff[DATA_W] ? DW_LO : DW_HI;
        end else begin
          // Leave the quotient to the divider
          d_q    <= d_q;
        end
      end
      S_DIV: begin
        rem_q <= qbit ? trial[DATA_W-1:0] : {rem_q[DATA_W-2:0], qsh_q[DATA_W-1]};
        qsh_q <= {qsh_q[DATA_W-2:0], qbit};
      end
      S_DFIN: begin
        d_q    <= quot_s;
        clip_q <= clip_q || quot_clip;
      end
      S_PMUL:  acc_q <= '0;
      S_IMUL2: acc_q <= acc_next;
      S_DMUL:  acc_q <= acc_next;
      S_SUM:   acc_q <= acc_next;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_clear_zeroes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_CLEAR |=> integral_q == '0 && prev_q == '0)
    else $error("clear word did not zero integral and previous error");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == '0 |=> state_q == S_DFIN)
    else $error("divider did not finish after its last step");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SAT && out_valid_q && !out_ready_i |=> state_q == S_SAT && out_valid_q)
    else $error("result overwritten while output register full");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_SAT || $past(state_q) == S_CLR)
    else $error("result raised outside a final step");
`endif

endmodule : pid_controller_integral_deadband_unit

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the PID step unit with integral deadband and integral clamp.
// Predicts each result word from its own fixed-point copy of the controller state.
// Depends on pidid_pkg and pid_controller_integral_deadband_unit.
`timescale 1ns / 1ps

module testbench
  import pidid_pkg::*;
();

  // Q16.16 and word constants
  localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
  localparam longint WORD_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint WORD_LO = -WORD_HI - 1;
  // First index past the register list
  localparam int IDX_SPARE_FIRST = CFG_DEADBAND + 1;

  typedef struct packed {
    logic [DATA_W-1:0] drive;
    logic [DATA_W-1:0] cur_error;
    logic              clipped;
    logic              dt_zero;
  } control_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     cmd_i = CMD_STEP;
  logic signed [DATA_W-1:0] set_point_i = '0;
  logic signed [DATA_W-1:0] measured_i = '0;
  logic        [DATA_W-1:0] time_step_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] drive_o;
  logic signed [DATA_W-1:0] current_error_o;
  logic                     drive_saturated_o;
  logic                     zero_step_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [DATA_W-1:0]        cfg_data_i = '0;

  // Controller state and settings as the block should hold them
  longint kp_gain = 0;
  longint ki_gain = 0;
  longint kd_gain = 0;
  longint integ_clamp = longint'({33'b0, LIMIT_RESET});
  longint integ_band = 0;
  longint integ_state = 0;
  longint last_err = 0;

  control_result_t control_results_due[$];
  int unsigned     mismatches = 0;
  int unsigned     results_seen = 0;
  bit              send_idle = 1'b1;
  bit              sink_idle = 1'b1;

  pid_controller_integral_deadband_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .set_point_i       (set_point_i),
    .measured_i        (measured_i),
    .time_step_i       (time_step_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_o           (drive_o),
    .current_error_o   (current_error_o),
    .drive_saturated_o (drive_saturated_o),
    .zero_step_o       (zero_step_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clip_word(longint x);
    if (x > WORD_HI) return WORD_HI;
    if (x < WORD_LO) return WORD_LO;
    return x;
  endfunction

  // Advance the controller by one word and return the result it should give
  function automatic control_result_t compute_control_step(logic cmd, logic [DATA_W-1:0] sp,
      logic [DATA_W-1:0] meas, logic [DATA_W-1:0] dt);
    control_result_t res;
    longint err, raw, mag, step_len, deriv, acc, total;
    res = '0;
    if (cmd == CMD_CLEAR) begin
      integ_state = 0;
      last_err = 0;
      return res;
    end
    step_len = longint'({32'b0, dt});
    raw = longint'($signed(sp)) - longint'($signed(meas));
    err = clip_word(raw);
    res.clipped = (err != raw);
    // Integrate only outside the deadband, then clamp
    mag = (err < 0) ? -err : err;
    if (mag > integ_band) begin
      integ_state = integ_state + ((err * step_len) >>> FRAC_BITS);
      if (integ_state > integ_clamp) integ_state = integ_clamp;
      if (integ_state < -integ_clamp) integ_state = -integ_clamp;
    end
    // Derivative truncates toward zero; a zero step forces it to zero
    if (dt == '0) begin
      res.dt_zero = 1'b1;
      deriv = 0;
    end else begin
      raw = ((err - last_err) <<< FRAC_BITS) / step_len;
      deriv = clip_word(raw);
      if (deriv != raw) res.clipped = 1'b1;
    end
    acc = ((kp_gain * err) >>> FRAC_BITS) + ((ki_gain * integ_state) >>> FRAC_BITS)
        + ((kd_gain * deriv) >>> FRAC_BITS);
    total = clip_word(acc);
    if (total != acc) res.clipped = 1'b1;
    last_err = err;
    res.drive = total[DATA_W-1:0];
    res.cur_error = err[DATA_W-1:0];
    return res;
  endfunction

  // Mostly values near zero, some full range, a few at the word limits
  function automatic logic [DATA_W-1:0] pick_value(int unsigned span);
    int near;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: begin
        near = int'($urandom_range(0, 2 * span)) - int'(span);
        return near;
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t: result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high
  task automatic send_word(logic cmd, logic [DATA_W-1:0] sp, logic [DATA_W-1:0] meas,
      logic [DATA_W-1:0] dt);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    set_point_i <= sp;
    measured_i  <= meas;
    time_step_i <= dt;
    @(posedge clk_i);
    while (!(in_valid_i && in_ready_o)) @(posedge clk_i);
    control_results_due.push_back(compute_control_step(cmd, sp, meas, dt));
    @(negedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    case (idx)
      CFG_GAIN_P:   kp_gain = longint'($signed(data));
      CFG_GAIN_I:   ki_gain = longint'($signed(data));
      CFG_GAIN_D:   kd_gain = longint'($signed(data));
      CFG_LIMIT:    integ_clamp = longint'({33'b0, data[MAG_W-1:0]});
      CFG_DEADBAND: integ_band = longint'({33'b0, data[MAG_W-1:0]});
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_settings(logic [DATA_W-1:0] kp, logic [DATA_W-1:0] ki,
      logic [DATA_W-1:0] kd, logic [DATA_W-1:0] lim, logic [DATA_W-1:0] band);
    cfg_write(CFG_GAIN_P, kp);
    cfg_write(CFG_GAIN_I, ki);
    cfg_write(CFG_GAIN_D, kd);
    cfg_write(CFG_LIMIT, lim);
    cfg_write(CFG_DEADBAND, band);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every outstanding word has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (control_results_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_control_result();
    control_result_t want;
    results_seen++;
    if (control_results_due.size() == 0) begin
      flag_mismatch("result word with nothing outstanding");
      return;
    end
    want = control_results_due.pop_front();
    if (drive_o !== want.drive)
      flag_mismatch($sformatf("drive %h, expected %h", drive_o, want.drive));
    if (current_error_o !== want.cur_error)
      flag_mismatch($sformatf("current_error %h, expected %h", current_error_o,
                              want.cur_error));
    if (drive_saturated_o !== want.clipped)
      flag_mismatch($sformatf("drive_saturated %b, expected %b", drive_saturated_o,
                              want.clipped));
    if (zero_step_o !== want.dt_zero)
      flag_mismatch($sformatf("zero_step %b, expected %b", zero_step_o, want.dt_zero));
  endtask

  // Accept result words with random back-pressure
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = sink_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      check_control_result();
    end
  end

  // Default settings after reset: zero gains, so drive stays zero
  task automatic test_reset_defaults();
    send_word(CMD_STEP, Q_ONE * 5, Q_ONE * 2, Q_ONE);
    send_word(CMD_STEP, Q_ONE, Q_ONE * 3, '0);
    send_word(CMD_STEP, '0, '0, Q_ONE);
    wait_results_drained();
  endtask

  // Error overflow both ways, zero and extreme time steps, clear
  task automatic test_error_extremes();
    write_settings(Q_ONE, Q_ONE / 2, Q_ONE / 4, Q_ONE * 100, '0);
    send_word(CMD_STEP, Q_MAX, Q_MIN, Q_ONE);
    send_word(CMD_STEP, Q_MIN, Q_MAX, 32'd1);
    send_word(CMD_STEP, '0, '0, '0);
    send_word(CMD_STEP, Q_ONE, '0, '1);
    send_word(CMD_CLEAR, '1, '1, '1);
    send_word(CMD_STEP, Q_ONE * 3, Q_ONE, Q_ONE / 8);
    send_word(CMD_CLEAR, '0, '0, '0);
    wait_results_drained();
  endtask

  // Deadband edge, clamp on both sides; top bit of the magnitude registers ignored
  task automatic test_deadband_clamp();
    write_settings('0, Q_ONE, '0, Q_MIN | (Q_ONE * 2), Q_MIN | Q_ONE);
    send_word(CMD_STEP, Q_ONE, '0, Q_ONE);
    send_word(CMD_STEP, Q_ONE + 1, '0, Q_ONE);
    send_word(CMD_STEP, '0, Q_ONE, Q_ONE);
    send_word(CMD_STEP, '0, Q_ONE + 1, Q_ONE);
    send_word(CMD_STEP, Q_ONE * 10, '0, Q_ONE);
    send_word(CMD_STEP, Q_ONE * 10, '0, Q_ONE);
    send_word(CMD_STEP, '0, Q_ONE * 10, Q_ONE);
    send_word(CMD_STEP, '0, Q_ONE * 10, Q_ONE);
    wait_results_drained();
    // Widest deadband: only the most negative error gets through
    write_settings('0, Q_ONE, '0, Q_MAX, Q_MAX);
    send_word(CMD_STEP, Q_MIN, '0, Q_ONE);
    send_word(CMD_STEP, Q_MAX, '0, Q_ONE);
    wait_results_drained();
    // Zero clamp pins the integral at zero
    write_settings('0, Q_ONE, '0, '0, '0);
    send_word(CMD_STEP, Q_ONE * 50, '0, Q_ONE * 4);
    wait_results_drained();
  endtask

  // Extreme gains drive the sum out of range; spare indexes must change nothing
  task automatic test_gain_extremes();
    for (int k = IDX_SPARE_FIRST; k < (1 << CFG_IDX_W); k++)
      cfg_write(k[CFG_IDX_W-1:0], $urandom);
    write_settings(Q_MAX, Q_MIN, Q_MAX, Q_MAX, '0);
    send_word(CMD_STEP, Q_MAX, '0, Q_ONE);
    send_word(CMD_STEP, Q_MIN, '0, Q_ONE);
    send_word(CMD_STEP, Q_ONE, Q_ONE, 32'd1);
    wait_results_drained();
    write_settings(Q_MIN, '0, Q_MIN, Q_MAX, '0);
    send_word(CMD_STEP, Q_ONE * 7, Q_ONE * 2, Q_ONE / 2);
    wait_results_drained();
  endtask

  // Control-loop traffic over several random settings
  task automatic test_random_control();
    logic [DATA_W-1:0] sp, meas, dt, lim, band;
    for (int phase = 0; phase < 7; phase++) begin
      wait_results_drained();
      lim = $urandom;
      band = $urandom;
      case ($urandom_range(0, 3))
        0: lim[MAG_W-1:0] = '0;
        1: lim[MAG_W-1:0] = '1;
        2: lim[MAG_W-1:0] = $urandom_range(0, 32'h0010_0000);
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: band[MAG_W-1:0] = '0;
        1: band[MAG_W-1:0] = '1;
        2: band[MAG_W-1:0] = $urandom_range(0, 32'h0000_4000);
        default: ;
      endcase
      write_settings(pick_value(32'h0002_0000), pick_value(32'h0002_0000),
                     pick_value(32'h0002_0000), lim, band);
      for (int n = 0; n < 100; n++) begin
        // Redraw idling so that some stretches run back to back
        if (n % 25 == 0) begin
          send_idle = ($urandom_range(0, 2) != 0);
          sink_idle = ($urandom_range(0, 2) != 0);
        end
        if ($urandom_range(0, 24) == 0) begin
          send_word(CMD_CLEAR, $urandom, $urandom, $urandom);
        end else begin
          sp = pick_value(32'h0008_0000);
          if ($urandom_range(0, 2) != 0) meas = sp - pick_value(32'h0002_0000);
          else meas = pick_value(32'h4000_0000);
          case ($urandom_range(0, 9))
            0: dt = '0;
            1: dt = $urandom_range(1, 4);
            2: dt = '1;
            3, 4: dt = $urandom;
            default: dt = $urandom_range(32'h0000_0400, 32'h0002_0000);
          endcase
          send_word(CMD_STEP, sp, meas, dt);
        end
      end
    end
    wait_results_drained();
  endtask

  initial begin : stimulus
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_error_extremes();
    test_deadband_clamp();
    test_gain_extremes();
    test_random_control();
    // Let any stray word surface before the verdict
    repeat (60) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
